@@ sv/lbc_pkg.sv @@
// shared types and constants for the block cache lookup core
`timescale 1ns / 1ps
package lbc_pkg;

    localparam int OFS_W   = 48;
    localparam int BLK_W   = 28;
    localparam int INB_W   = 30;
    localparam int LEN_W   = 31;
    localparam int MIB_SH  = 20;
    localparam int MIB_W   = 11;
    localparam int MAXE_W  = 5;
    localparam int REM_W   = 10;
    localparam int ERR_W   = 2;
    localparam int DIV_STEPS = BLK_W;
    localparam int DCNT_W  = $clog2(DIV_STEPS);
    localparam int Q_DEPTH = 2;
    localparam int QPTR_W  = $clog2(Q_DEPTH);
    localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

    localparam logic [MIB_W-1:0]  MIB_MAX      = MIB_W'(1024);
    localparam logic [MIB_W-1:0]  MIB_RESET    = MIB_W'(1);
    localparam logic [MAXE_W-1:0] MAXE_DEFAULT = MAXE_W'(16);

    localparam logic CFG_BLOCK_MIB   = 1'b0;
    localparam logic CFG_MAX_ENTRIES = 1'b1;

    localparam logic [ERR_W-1:0] ERR_OK      = 2'd0;
    localparam logic [ERR_W-1:0] ERR_BEYOND  = 2'd1;
    localparam logic [ERR_W-1:0] ERR_FETCH   = 2'd2;

    typedef struct packed {
        logic [BLK_W-1:0] blk;
        logic [INB_W-1:0] inblk;
        logic [OFS_W-1:0] start;
        logic             fetch_ok;
        logic             size_rep;
        logic [OFS_W-1:0] rep_size;
    } t_job;

    typedef struct packed {
        logic             hit;
        logic [ERR_W-1:0] err;
        logic [BLK_W-1:0] blk;
        logic [INB_W-1:0] inblk;
        logic [LEN_W-1:0] flen;
        logic             ev;
        logic [BLK_W-1:0] evblk;
    } t_result;

endpackage

@@ sv/lru_block_cache_lookup_core.sv @@
// top level of the block cache lookup core with configuration registers
//
//  channel  direction  handshake                 payload
//  in       input      i_in_valid / o_in_stall   offset, fetch outcome, reported size
//  out      output     o_out_valid / i_out_stall hit, error, block, offset, length, eviction
//  cfg      input      i_cfg_valid / o_cfg_ready index, data
//
// in the front end a request is captured, then come 28 steps of the restoring divider
// on the offset in mebibytes, then the job is handed to the queue, waiting while it is full
// the back end looks up and updates the tag store in one cycle per job while the output is not stalled
// reset clears all valid bits, counts, the learned file size and the queue
// a stalled output holds its result; up to two jobs wait in the queue meanwhile
`timescale 1ns / 1ps
module lru_block_cache_lookup_core #(
    parameter int MAX_BLOCKS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [lbc_pkg::OFS_W-1:0]     i_byte_offset,
    input  logic                          i_fetch_ok,
    input  logic                          i_size_reported,
    input  logic [lbc_pkg::OFS_W-1:0]     i_reported_size,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_hit,
    output logic [lbc_pkg::ERR_W-1:0]     o_error_code,
    output logic [lbc_pkg::BLK_W-1:0]     o_block_number,
    output logic [lbc_pkg::INB_W-1:0]     o_offset_in_block,
    output logic [lbc_pkg::LEN_W-1:0]     o_fetch_length,
    output logic                          o_evicted,
    output logic [lbc_pkg::BLK_W-1:0]     o_evicted_block,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic                          i_cfg_index,
    input  logic [lbc_pkg::MIB_W-1:0]     i_cfg_data
);

    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);

    logic [lbc_pkg::MIB_W-1:0]  r_blk_mib;
    logic [lbc_pkg::MAXE_W-1:0] r_max_ent;
    logic [lbc_pkg::MIB_W-1:0]  w_mib_eff;
    logic [lbc_pkg::MAXE_W-1:0] w_cap_raw;
    logic [CNT_W-1:0]           w_cap;
    logic                       w_push, w_pop, w_full, w_nempty;
    lbc_pkg::t_job              w_fjob, w_qjob;
    lbc_pkg::t_result           w_res;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blk_mib <= lbc_pkg::MIB_RESET;
            r_max_ent <= lbc_pkg::MAXE_DEFAULT;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                lbc_pkg::CFG_BLOCK_MIB:   r_blk_mib <= i_cfg_data;
                lbc_pkg::CFG_MAX_ENTRIES: r_max_ent <= i_cfg_data[lbc_pkg::MAXE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_blk_mib == '0) begin
            w_mib_eff = lbc_pkg::MIB_RESET;
        end else if (r_blk_mib > lbc_pkg::MIB_MAX) begin
            w_mib_eff = lbc_pkg::MIB_MAX;
        end else begin
            w_mib_eff = r_blk_mib;
        end
        w_cap_raw = (r_max_ent == '0) ? lbc_pkg::MAXE_DEFAULT : r_max_ent;
        if (32'(w_cap_raw) > MAX_BLOCKS) begin
            w_cap = CNT_W'(MAX_BLOCKS);
        end else begin
            w_cap = CNT_W'(w_cap_raw);
        end
    end

    lbc_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_byte_offset   (i_byte_offset),
        .i_fetch_ok      (i_fetch_ok),
        .i_size_reported (i_size_reported),
        .i_reported_size (i_reported_size),
        .i_blk_mib       (w_mib_eff),
        .i_q_full        (w_full),
        .o_push          (w_push),
        .o_job           (w_fjob)
    );

    lbc_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_job    (w_fjob),
        .o_full   (w_full),
        .i_pop    (w_pop),
        .o_nempty (w_nempty),
        .o_job    (w_qjob)
    );

    lbc_back #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_nempty    (w_nempty),
        .i_job       (w_qjob),
        .o_pop       (w_pop),
        .i_blk_mib   (w_mib_eff),
        .i_cap       (w_cap),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_res       (w_res)
    );

    assign o_hit             = w_res.hit;
    assign o_error_code      = w_res.err;
    assign o_block_number    = w_res.blk;
    assign o_offset_in_block = w_res.inblk;
    assign o_fetch_length    = w_res.flen;
    assign o_evicted         = w_res.ev;
    assign o_evicted_block   = w_res.evblk;

endmodule

@@ sv/lbc_front.sv @@
// front end: accepts requests and splits the offset into block number and offset
`timescale 1ns / 1ps
module lbc_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [lbc_pkg::OFS_W-1:0]  i_byte_offset,
    input  logic                       i_fetch_ok,
    input  logic                       i_size_reported,
    input  logic [lbc_pkg::OFS_W-1:0]  i_reported_size,
    input  logic [lbc_pkg::MIB_W-1:0]  i_blk_mib,
    input  logic                       i_q_full,
    output logic                       o_push,
    output lbc_pkg::t_job              o_job
);

    localparam logic [1:0] FS_IDLE = 2'd0;
    localparam logic [1:0] FS_DIV  = 2'd1;
    localparam logic [1:0] FS_PUSH = 2'd2;

    logic [1:0]                    r_state, n_state;
    logic [lbc_pkg::DCNT_W-1:0]    r_cnt, n_cnt;
    logic [lbc_pkg::BLK_W-1:0]     r_num, n_num;
    logic [lbc_pkg::BLK_W-1:0]     r_quo, n_quo;
    logic [lbc_pkg::MIB_W-1:0]     r_rem, n_rem;
    logic [lbc_pkg::OFS_W-1:0]     r_ofs, r_rsize;
    logic                          r_fok, r_srep;
    logic [lbc_pkg::MIB_W:0]       w_trial;
    logic [lbc_pkg::MIB_W:0]       w_sub;
    logic [lbc_pkg::INB_W-1:0]     w_inblk;

    assign o_in_stall = (r_state != FS_IDLE);
    assign o_push     = (r_state == FS_PUSH) && !i_q_full;

    assign w_trial = {r_rem, r_num[lbc_pkg::BLK_W-1]};
    assign w_sub   = w_trial - {1'b0, i_blk_mib};
    assign w_inblk = {r_rem[lbc_pkg::REM_W-1:0], r_ofs[lbc_pkg::MIB_SH-1:0]};

    always_comb begin
        o_job.blk      = r_quo;
        o_job.inblk    = w_inblk;
        o_job.start    = r_ofs - lbc_pkg::OFS_W'(w_inblk);
        o_job.fetch_ok = r_fok;
        o_job.size_rep = r_srep;
        o_job.rep_size = r_rsize;
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_num   = r_num;
        n_quo   = r_quo;
        n_rem   = r_rem;
        unique case (r_state)
            FS_IDLE: begin
                if (i_in_valid) begin
                    n_state = FS_DIV;
                    n_cnt   = '0;
                    n_num   = i_byte_offset[lbc_pkg::OFS_W-1:lbc_pkg::MIB_SH];
                    n_quo   = '0;
                    n_rem   = '0;
                end
            end
            FS_DIV: begin
                n_num = {r_num[lbc_pkg::BLK_W-2:0], 1'b0};
                if (w_trial >= {1'b0, i_blk_mib}) begin
                    n_rem = w_sub[lbc_pkg::MIB_W-1:0];
                    n_quo = {r_quo[lbc_pkg::BLK_W-2:0], 1'b1};
                end else begin
                    n_rem = w_trial[lbc_pkg::MIB_W-1:0];
                    n_quo = {r_quo[lbc_pkg::BLK_W-2:0], 1'b0};
                end
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == lbc_pkg::DCNT_W'(lbc_pkg::DIV_STEPS - 1)) begin
                    n_state = FS_PUSH;
                end
            end
            FS_PUSH: begin
                if (!i_q_full) begin
                    n_state = FS_IDLE;
                end
            end
            default: n_state = FS_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FS_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_cnt <= n_cnt;
        r_num <= n_num;
        r_quo <= n_quo;
        r_rem <= n_rem;
        if (r_state == FS_IDLE && i_in_valid) begin
            r_ofs   <= i_byte_offset;
            r_fok   <= i_fetch_ok;
            r_srep  <= i_size_reported;
            r_rsize <= i_reported_size;
        end
    end

endmodule

@@ sv/lbc_queue.sv @@
// short job queue between front and back
`timescale 1ns / 1ps
module lbc_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  lbc_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_nempty,
    output lbc_pkg::t_job o_job
);

    lbc_pkg::t_job                 r_mem [lbc_pkg::Q_DEPTH];
    logic [lbc_pkg::QPTR_W-1:0]    r_wp, r_rp;
    logic [lbc_pkg::QCNT_W-1:0]    r_cnt;

    assign o_full   = (r_cnt == lbc_pkg::QCNT_W'(lbc_pkg::Q_DEPTH));
    assign o_nempty = (r_cnt != '0);
    assign o_job    = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

endmodule

@@ sv/lbc_back.sv @@
// back end: tag store with recency ranks, file size tracking and result register
`timescale 1ns / 1ps
module lbc_back #(
    parameter int MAX_BLOCKS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_nempty,
    input  lbc_pkg::t_job                       i_job,
    output logic                                o_pop,
    input  logic [lbc_pkg::MIB_W-1:0]           i_blk_mib,
    input  logic [$clog2(MAX_BLOCKS+1)-1:0]     i_cap,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output lbc_pkg::t_result                    o_res
);

    localparam int RANK_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);

    logic [lbc_pkg::BLK_W-1:0] r_tag   [MAX_BLOCKS];
    logic [RANK_W-1:0]         r_rank  [MAX_BLOCKS];
    logic [RANK_W-1:0]         n_rank  [MAX_BLOCKS];
    logic [MAX_BLOCKS-1:0]     r_valid, n_valid;
    logic [CNT_W-1:0]          r_count, n_count;
    logic [lbc_pkg::OFS_W-1:0] r_fsize;
    logic                      r_fsk;
    logic                      r_out_valid;
    lbc_pkg::t_result          r_res, n_res;

    logic [MAX_BLOCKS-1:0]     w_match, w_evm, w_free;
    logic                      w_hit, w_beyond, w_ins, w_ev, w_slot_found;
    logic [RANK_W-1:0]         w_hrank;
    logic [lbc_pkg::OFS_W-1:0] w_diff;
    logic [lbc_pkg::LEN_W-1:0] w_bb;
    logic [CNT_W-1:0]          w_cap_m1;
    logic [lbc_pkg::BLK_W-1:0] w_evblk;
    logic [MAX_BLOCKS-1:0]     w_slot;

    assign o_pop       = i_nempty && (!r_out_valid || !i_out_stall);
    assign o_out_valid = r_out_valid;
    assign o_res       = r_res;

    assign w_bb     = {i_blk_mib, {lbc_pkg::MIB_SH{1'b0}}};
    assign w_diff   = r_fsize - i_job.start;
    assign w_beyond = r_fsk && (i_job.start >= r_fsize);
    assign w_cap_m1 = i_cap - 1'b1;

    always_comb begin
        w_hrank = '0;
        w_evblk = '0;
        for (int i = 0; i < MAX_BLOCKS; i++) begin
            w_match[i] = r_valid[i] && (r_tag[i] == i_job.blk);
            if (w_match[i]) begin
                w_hrank = w_hrank | r_rank[i];
            end
        end
        w_hit = |w_match;
        w_ins = !w_hit && !w_beyond && i_job.fetch_ok;
        w_ev  = w_ins && (r_count >= i_cap);
        for (int i = 0; i < MAX_BLOCKS; i++) begin
            w_evm[i] = w_ev && r_valid[i] && (CNT_W'(r_rank[i]) >= w_cap_m1);
            if (w_ev && r_valid[i] && (CNT_W'(r_rank[i]) == w_cap_m1)) begin
                w_evblk = w_evblk | r_tag[i];
            end
        end
        w_free       = ~r_valid | w_evm;
        w_slot       = '0;
        w_slot_found = 1'b0;
        for (int i = 0; i < MAX_BLOCKS; i++) begin
            if (w_free[i] && !w_slot_found) begin
                w_slot[i]    = 1'b1;
                w_slot_found = 1'b1;
            end
        end
    end

    always_comb begin
        n_valid = r_valid;
        n_count = r_count;
        for (int i = 0; i < MAX_BLOCKS; i++) begin
            n_rank[i] = r_rank[i];
        end
        if (w_hit) begin
            for (int i = 0; i < MAX_BLOCKS; i++) begin
                if (w_match[i]) begin
                    n_rank[i] = '0;
                end else if (r_valid[i] && (r_rank[i] < w_hrank)) begin
                    n_rank[i] = r_rank[i] + 1'b1;
                end
            end
        end else if (w_ins) begin
            for (int i = 0; i < MAX_BLOCKS; i++) begin
                if (w_slot[i]) begin
                    n_valid[i] = 1'b1;
                    n_rank[i]  = '0;
                end else if (w_evm[i]) begin
                    n_valid[i] = 1'b0;
                end else if (r_valid[i]) begin
                    n_rank[i] = r_rank[i] + 1'b1;
                end
            end
            n_count = w_ev ? i_cap : r_count + 1'b1;
        end

        n_res.hit   = w_hit;
        n_res.blk   = i_job.blk;
        n_res.inblk = i_job.inblk;
        n_res.ev    = w_ev;
        n_res.evblk = w_evblk;
        n_res.err   = lbc_pkg::ERR_OK;
        n_res.flen  = '0;
        if (!w_hit) begin
            if (w_beyond) begin
                n_res.err = lbc_pkg::ERR_BEYOND;
            end else begin
                if (r_fsk && (w_diff < lbc_pkg::OFS_W'(w_bb))) begin
                    n_res.flen = w_diff[lbc_pkg::LEN_W-1:0];
                end else begin
                    n_res.flen = w_bb;
                end
                if (!i_job.fetch_ok) begin
                    n_res.err = lbc_pkg::ERR_FETCH;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_count     <= '0;
            r_fsk       <= 1'b0;
            r_fsize     <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < MAX_BLOCKS; i++) begin
                r_rank[i] <= '0;
            end
        end else begin
            if (o_pop) begin
                r_valid <= n_valid;
                r_count <= n_count;
                for (int i = 0; i < MAX_BLOCKS; i++) begin
                    r_rank[i] <= n_rank[i];
                end
                if (w_ins && i_job.size_rep) begin
                    r_fsize <= i_job.rep_size;
                    r_fsk   <= 1'b1;
                end
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
        if (o_pop) begin
            r_res <= n_res;
            for (int i = 0; i < MAX_BLOCKS; i++) begin
                if (w_ins && w_slot[i]) begin
                    r_tag[i] <= i_job.blk;
                end
            end
        end
    end

endmodule
